@@ hdl/ptc_pkg.sv @@
// Shared types and constants for the pressure and temperature compensation pipeline.
package ptc_pkg;

    localparam int PIPE_DEPTH = 6;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int DT_W    = 25;
    localparam int MUL_W   = 42;
    localparam int TEMP_W  = 19;
    localparam int OFF_W   = 35;
    localparam int SENS_W  = 34;
    localparam int PRESS_W = 32;
    localparam int IDX_W   = 3;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    typedef enum logic [IDX_W-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] en;
    } t_pipe_ctl;

    typedef struct packed {
        logic        [RAW_W-1:0]  d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_coef;

endpackage

@@ hdl/pressure_temperature_compensation.sv @@
// Top level of the first-order barometric pressure and temperature compensation.
//
//   channel  direction  word contents (lowest bits first)
//   s_axis   in         raw_pressure[23:0], raw_temperature[47:24]
//   m_axis   out        temperature_centidegrees[18:0], pressure_centimillibar[50:19]
//   cfg      in         i_cfg_index selects C1..C6, i_cfg_data holds the 16-bit word
//
// Six register stages; one word can enter every cycle unless a stall on m_axis has filled
// every stage up to the input. The longest stage holds a 25 by 17 bit multiplier.
// Reset clears the valid bits and the calibration words to zero.
// A stall on m_axis holds only the full stages from the output back to the first empty one; empty stages still fill.
// Configuration writes are always taken; indexes six and seven are ignored.
module pressure_temperature_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // raw_pressure, raw_temperature
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // temperature_centidegrees, pressure_centimillibar, zeros
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ptc_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    ptc_pkg::t_cal      r_cal;
    ptc_pkg::t_pipe_ctl w_ctl;
    ptc_pkg::t_coef     w_coef;

    logic signed [ptc_pkg::TEMP_W-1:0]  w_temp;
    logic signed [ptc_pkg::PRESS_W-1:0] w_press;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ptc_pkg::CFG_C1: r_cal.c1 <= i_cfg_data;
                ptc_pkg::CFG_C2: r_cal.c2 <= i_cfg_data;
                ptc_pkg::CFG_C3: r_cal.c3 <= i_cfg_data;
                ptc_pkg::CFG_C4: r_cal.c4 <= i_cfg_data;
                ptc_pkg::CFG_C5: r_cal.c5 <= i_cfg_data;
                ptc_pkg::CFG_C6: r_cal.c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ptc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl)
    );

    ptc_coef u_coef (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_cal  (r_cal),
        .i_d1   (s_axis_tdata[23:0]),
        .i_d2   (s_axis_tdata[47:24]),
        .o_coef (w_coef)
    );

    ptc_press u_press (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_coef  (w_coef),
        .o_temp  (w_temp),
        .o_press (w_press)
    );

    assign m_axis_tdata = {5'b00000, w_press, w_temp};

    // Input back-pressure only ever comes from a stalled result.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a stalled result");

    // The scaled pressure never needs more than 24 bits.
    a_press_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[50:42] == 9'h000 || m_axis_tdata[50:42] == 9'h1FF))
        else $error("pressure beyond its 24-bit range");

    // A stalled result while the input is held off keeps a valid result at the output.
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && !s_axis_tready) |=> m_axis_tvalid)
        else $error("result lost during a full-pipeline stall");

endmodule

@@ hdl/ptc_pipe_ctrl.sv @@
// Valid bits and per-stage load enables for the compensation pipeline.
module ptc_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ptc_pkg::t_pipe_ctl  o_ctl
);

    localparam int D = ptc_pkg::PIPE_DEPTH;

    logic [D-1:0] r_vld;
    logic [D-1:0] n_vld;
    logic [D-1:0] w_rdy;

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        w_rdy[D-1] = !r_vld[D-1] || i_out_ready;
        for (int k = D - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        n_vld[0] = w_rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < D; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[D-1];
    assign o_ctl.en    = w_rdy;

endmodule

@@ hdl/ptc_coef.sv @@
// Stages one to three: temperature difference, the three tempco products, TEMP, OFF and SENS.
module ptc_coef (
    input  logic                               i_clk,
    input  ptc_pkg::t_pipe_ctl                 i_ctl,
    input  ptc_pkg::t_cal                      i_cal,
    input  logic [ptc_pkg::RAW_W-1:0]          i_d1,
    input  logic [ptc_pkg::RAW_W-1:0]          i_d2,
    output ptc_pkg::t_coef                     o_coef
);

    // Stage one
    logic        [ptc_pkg::RAW_W-1:0] r_d1_s1;
    logic signed [ptc_pkg::DT_W-1:0]  r_dt;
    // Stage two
    logic        [ptc_pkg::RAW_W-1:0] r_d1_s2;
    logic signed [ptc_pkg::MUL_W-1:0] r_prod_t;
    logic signed [ptc_pkg::MUL_W-1:0] r_prod_o;
    logic signed [ptc_pkg::MUL_W-1:0] r_prod_s;
    // Stage three
    ptc_pkg::t_coef r_coef;

    logic signed [ptc_pkg::CAL_W:0] w_c3;
    logic signed [ptc_pkg::CAL_W:0] w_c4;
    logic signed [ptc_pkg::CAL_W:0] w_c6;

    assign w_c3 = $signed({1'b0, i_cal.c3});
    assign w_c4 = $signed({1'b0, i_cal.c4});
    assign w_c6 = $signed({1'b0, i_cal.c6});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_d1_s1 <= i_d1;
            r_dt    <= $signed({1'b0, i_d2}) - $signed({1'b0, i_cal.c5, 8'h00});
        end
        if (i_ctl.en[1]) begin
            r_d1_s2  <= r_d1_s1;
            r_prod_t <= r_dt * w_c6;
            r_prod_o <= r_dt * w_c4;
            r_prod_s <= r_dt * w_c3;
        end
        // Part-selects of the products are the floor shifts by 23, 7 and 8.
        if (i_ctl.en[2]) begin
            r_coef.d1   <= r_d1_s2;
            r_coef.temp <= ptc_pkg::TEMP_BASE + $signed(r_prod_t[41:23]);
            r_coef.off  <= $signed({3'b000, i_cal.c2, 16'h0000}) + $signed(r_prod_o[41:7]);
            r_coef.sens <= $signed({3'b000, i_cal.c1, 15'h0000}) + $signed(r_prod_s[41:8]);
        end
    end

    assign o_coef = r_coef;

endmodule

@@ hdl/ptc_press.sv @@
// Stages four to six: D1 times SENS in two partial products, offset removal and scaling.
module ptc_press (
    input  logic                                  i_clk,
    input  ptc_pkg::t_pipe_ctl                    i_ctl,
    input  ptc_pkg::t_coef                        i_coef,
    output logic signed [ptc_pkg::TEMP_W-1:0]     o_temp,
    output logic signed [ptc_pkg::PRESS_W-1:0]    o_press
);

    // Stage four
    logic        [40:0]                   r_pl;
    logic signed [41:0]                   r_ph;
    logic signed [ptc_pkg::OFF_W-1:0]     r_off_s4;
    logic signed [ptc_pkg::TEMP_W-1:0]    r_temp_s4;
    // Stage five
    logic signed [58:0]                   r_prod;
    logic signed [ptc_pkg::OFF_W-1:0]     r_off_s5;
    logic signed [ptc_pkg::TEMP_W-1:0]    r_temp_s5;
    // Stage six
    logic signed [ptc_pkg::TEMP_W-1:0]    r_temp;
    logic signed [ptc_pkg::PRESS_W-1:0]   r_press;

    logic signed [38:0] w_diff;

    // floor(D1*SENS / 2^21) - OFF; the product shifted fits 38 bits, the difference 39.
    assign w_diff = $signed({r_prod[58], r_prod[58:21]})
                  - $signed({{4{r_off_s5[ptc_pkg::OFF_W-1]}}, r_off_s5});

    always_ff @(posedge i_clk) begin
        // SENS splits into an unsigned low part of 17 bits and a signed high part.
        if (i_ctl.en[3]) begin
            r_pl      <= i_coef.d1 * i_coef.sens[16:0];
            r_ph      <= $signed({1'b0, i_coef.d1}) * $signed(i_coef.sens[33:17]);
            r_off_s4  <= i_coef.off;
            r_temp_s4 <= i_coef.temp;
        end
        if (i_ctl.en[4]) begin
            r_prod    <= $signed({r_ph, 17'h00000}) + $signed({18'h00000, r_pl});
            r_off_s5  <= r_off_s4;
            r_temp_s5 <= r_temp_s4;
        end
        // The scaled pressure spans 24 bits, so widening to 32 bits is the saturation.
        if (i_ctl.en[5]) begin
            r_temp  <= r_temp_s5;
            r_press <= $signed({{8{w_diff[38]}}, w_diff[38:15]});
        end
    end

    assign o_temp  = r_temp;
    assign o_press = r_press;

endmodule

@@ dv/ptc_compensation_checker.sv @@
// Checker that predicts the compensated readings and compares them with the block's output.
`timescale 1ns / 100ps

module ptc_compensation_checker
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_raw_valid,
    input  logic        i_raw_ready,
    input  logic [47:0] i_raw_data,
    input  logic        i_comp_valid,
    input  logic        i_comp_ready,
    input  logic [55:0] i_comp_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatch_count,
    output int          o_pending
);

    localparam longint PRESS_MAX   = 64'sd2147483647;
    localparam longint PRESS_MIN   = -64'sd2147483648;

    typedef struct {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [PRESS_W-1:0] press;
    } t_reading;

    t_cal     cal_words;
    t_reading expected_readings[$];

    // All divisions by powers of two are floors, which >>> gives on signed operands.
    function automatic t_reading compensate(input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw);
        longint   d1, d2, c1, c2, c3, c4, c5, c6;
        longint   dt, temp, off, sens, press;
        t_reading r;
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = cal_words.c1;
        c2 = cal_words.c2;
        c3 = cal_words.c3;
        c4 = cal_words.c4;
        c5 = cal_words.c5;
        c6 = cal_words.c6;
        dt    = d2 - c5 * 256;
        temp  = 2000 + ((dt * c6) >>> 23);
        off   = c2 * 65536 + ((c4 * dt) >>> 7);
        sens  = c1 * 32768 + ((c3 * dt) >>> 8);
        press = (((d1 * sens) >>> 21) - off) >>> 15;
        if (press > PRESS_MAX) begin
            press = PRESS_MAX;
        end
        if (press < PRESS_MIN) begin
            press = PRESS_MIN;
        end
        r.temp  = temp[TEMP_W-1:0];
        r.press = press[PRESS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        o_mismatch_count++;
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_reading(input logic [55:0] word);
        t_reading                  want;
        logic signed [TEMP_W-1:0]  got_temp;
        logic signed [PRESS_W-1:0] got_press;
        got_temp  = word[18:0];
        got_press = word[50:19];
        if (expected_readings.size() == 0) begin
            report_mismatch("unexpected output word, temperature", got_temp, 0);
        end else begin
            want = expected_readings.pop_front();
            if (got_temp !== want.temp) begin
                report_mismatch("temperature_centidegrees", got_temp, want.temp);
            end
            if (got_press !== want.press) begin
                report_mismatch("pressure_centimillibar", got_press, want.press);
            end
            if (word[55:51] !== 5'd0) begin
                report_mismatch("padding bits", word[55:51], 0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_words <= '0;
            expected_readings.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_C1: cal_words.c1 <= i_cfg_data;
                    CFG_C2: cal_words.c2 <= i_cfg_data;
                    CFG_C3: cal_words.c3 <= i_cfg_data;
                    CFG_C4: cal_words.c4 <= i_cfg_data;
                    CFG_C5: cal_words.c5 <= i_cfg_data;
                    CFG_C6: cal_words.c6 <= i_cfg_data;
                    default: ;
                endcase
            end
            // Pop before push so a word leaving and one entering on the same edge stay ordered.
            if (i_comp_valid && i_comp_ready) begin
                check_reading(i_comp_data);
            end
            if (i_raw_valid && i_raw_ready) begin
                expected_readings.push_back(compensate(i_raw_data[23:0], i_raw_data[47:24]));
            end
            o_pending <= expected_readings.size();
        end
    end

endmodule

@@ dv/pressure_temperature_compensation_test.sv @@
// Top of the compensation testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module pressure_temperature_compensation_test;
    import ptc_pkg::*;

    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [RAW_W-1:0] RAW_MAX      = 24'hFFFFFF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    int   mismatch_count;
    int   pending_readings;
    int   tx_idle_pct;
    int   rx_stall_pct;
    t_cal cur_cal;

    pressure_temperature_compensation DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ptc_compensation_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_raw_valid      (s_axis_tvalid),
        .i_raw_ready      (s_axis_tready),
        .i_raw_data       (s_axis_tdata),
        .i_comp_valid     (m_axis_tvalid),
        .i_comp_ready     (m_axis_tready),
        .i_comp_data      (m_axis_tdata),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_readings)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("pressure_temperature_compensation_test failed");
        $finish;
    end

    // Output side: random stalls while enabled, otherwise always ready.
    initial begin
        forever begin
            if ($urandom_range(0, 99) < rx_stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    task automatic send_raw(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d2, d1};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_word(input logic [IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes the six calibration words; optionally hits the unused indexes too.
    task automatic load_cal(input t_cal cal, input bit poke_spare);
        write_word(CFG_C1, cal.c1);
        write_word(CFG_C2, cal.c2);
        write_word(CFG_C3, cal.c3);
        write_word(CFG_C4, cal.c4);
        write_word(CFG_C5, cal.c5);
        write_word(CFG_C6, cal.c6);
        if (poke_spare) begin
            write_word(CFG_SPARE_LO, 16'($urandom));
            write_word(CFG_SPARE_HI, 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
        cur_cal = cal;
    endtask

    // Lowers valid, then waits for every word in flight to come out.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_cal_word;
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Temperature readings mostly sit near the reference point set by C5.
    function automatic logic [RAW_W-1:0] random_raw_temperature;
        longint v;
        if ($urandom_range(0, 9) < 3) begin
            return RAW_W'($urandom);
        end
        v = longint'(cur_cal.c5) * 256 + $urandom_range(0, 131071) - 65536;
        if (v < 0) begin
            v = 0;
        end
        if (v > RAW_MAX) begin
            v = RAW_MAX;
        end
        return v[RAW_W-1:0];
    endfunction

    task automatic run_directed;
        t_cal cal;
        // Calibration words still at their reset value.
        send_raw(24'd0, 24'd0);
        send_raw(RAW_MAX, RAW_MAX);
        drain();

        // A typical calibration, with dT exactly zero and just below zero.
        cal = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
        load_cal(cal, 1'b1);
        send_raw(24'd0, 24'd0);
        send_raw(RAW_MAX, 24'd0);
        send_raw(24'd0, RAW_MAX);
        send_raw(RAW_MAX, RAW_MAX);
        send_raw(24'd9085466, 24'd8569150);
        send_raw(24'd9085466, {cal.c5, 8'd0});
        send_raw(24'd9085466, {cal.c5, 8'd0} - 24'd1);
        send_raw(24'hAAAAAA, 24'h555555);
        send_raw(24'h555555, 24'hAAAAAA);
        drain();

        // Every word at its maximum: large negative dT drives SENS and OFF negative.
        cal = '{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF,
                c4: 16'hFFFF, c5: 16'hFFFF, c6: 16'hFFFF};
        load_cal(cal, 1'b0);
        send_raw(24'd0, 24'd0);
        send_raw(RAW_MAX, 24'd0);
        send_raw(24'd0, RAW_MAX);
        send_raw(RAW_MAX, RAW_MAX);
        drain();

        // Sensitivity only from its temperature term, so it is negative.
        cal = '{c1: 16'h0000, c2: 16'h0000, c3: 16'hFFFF,
                c4: 16'hFFFF, c5: 16'hFFFF, c6: 16'h0000};
        load_cal(cal, 1'b0);
        send_raw(RAW_MAX, 24'd0);
        send_raw(24'd1, 24'd0);
        drain();

        // Zero reference temperature with the steepest slope gives the highest temperature.
        cal = '{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF,
                c4: 16'hFFFF, c5: 16'h0000, c6: 16'hFFFF};
        load_cal(cal, 1'b0);
        send_raw(RAW_MAX, RAW_MAX);
        send_raw(24'd0, RAW_MAX);
        drain();
    endtask

    initial begin
        t_cal cal;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_C1;
        i_cfg_data    <= '0;
        tx_idle_pct   = 25;
        rx_stall_pct  = 25;
        cur_cal       = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            cal.c1 = random_cal_word();
            cal.c2 = random_cal_word();
            cal.c3 = random_cal_word();
            cal.c4 = random_cal_word();
            cal.c5 = random_cal_word();
            cal.c6 = random_cal_word();
            load_cal(cal, phase[0]);
            // The last phase runs at full rate on both sides.
            if (phase == RANDOM_PHASES - 1) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end else begin
                tx_idle_pct  = $urandom_range(0, 40);
                rx_stall_pct = $urandom_range(0, 40);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_raw(RAW_W'($urandom), random_raw_temperature());
            end
            drain();
        end

        if (mismatch_count == 0) begin
            $display("pressure_temperature_compensation_test passed");
        end else begin
            $display("pressure_temperature_compensation_test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ptc_pkg.sv
hdl/ptc_pipe_ctrl.sv
hdl/ptc_coef.sv
hdl/ptc_press.sv
hdl/pressure_temperature_compensation.sv
dv/ptc_compensation_checker.sv
dv/pressure_temperature_compensation_test.sv
